>>> sv/bmp_pkg.sv
`timescale 1ns / 1ps

package bmp_pkg;

   // Modulus and residue width
   localparam int MOD_W = 30;

   // Modulus after reset
   localparam logic [MOD_W-1:0] MOD_RESET = 30'd998244353;

   // Request to the shared modular multiplier
   typedef struct packed {
      logic             start;
      logic [MOD_W-1:0] op_a;
      logic [MOD_W-1:0] op_b;
      logic [MOD_W-1:0] modulus;
   } bmp_mm_req_type;

   // Reply from the shared modular multiplier
   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] value;
   } bmp_mm_rsp_type;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_FACT    = 7'b0000010,
      ST_POW_CHK = 7'b0000100,
      ST_POW_ACC = 7'b0001000,
      ST_POW_SQ  = 7'b0010000,
      ST_FIN     = 7'b0100000,
      ST_DONE    = 7'b1000000
   } bmp_state_type;

endpackage

>>> sv/binomial_mod_prime_unit.sv
`timescale 1ns / 1ps
// Each modular multiply runs on the single shared multiplier.
// An item with 0 < r <= n costs n multiplies for the factorials, up to 59 per
// Fermat inverse (two of them) and two final multiplies, plus a check state per
// exponent bit, for a 30-bit modulus. Trivial cases (r = 0, r > n, p < 2) skip
// the multiplier. One item at a time; the result register frees the input side once loaded.
// Reset (synchronous, active high) clears control and sets the modulus to 998244353.
module binomial_mod_prime_unit
   import bmp_pkg::*;
#(
   parameter int N_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [N_BITS-1:0] req_n_value,
   input  logic [N_BITS-1:0] req_r_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [MOD_W-1:0]  rsp_result,
   input  logic              csr_write_enable,
   input  logic [MOD_W-1:0]  csr_write_data
);

   bmp_state_type  state_ff, state_in;
   logic [N_BITS-1:0] n_ff, n_in;
   logic [N_BITS-1:0] r_ff, r_in;
   logic [N_BITS-1:0] k_ff, k_in;
   logic [N_BITS-1:0] i_ff, i_in;
   logic [MOD_W-1:0]  imod_ff, imod_in;
   logic [MOD_W-1:0]  factr_ff, factr_in;
   logic [MOD_W-1:0]  factk_ff, factk_in;
   logic [MOD_W-1:0]  acc_ff, acc_in;
   logic [MOD_W-1:0]  sq_ff, sq_in;
   logic [MOD_W-1:0]  exp_ff, exp_in;
   logic [MOD_W-1:0]  res_ff, res_in;
   logic              second_ff, second_in;
   logic [MOD_W-1:0]  mod_ff, mod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]  rsp_result_ff, rsp_result_in;
   bmp_mm_req_type    mm_req_ff, mm_req_in;
   bmp_mm_rsp_type    mm_rsp;

   logic [MOD_W-1:0] imod_inc;
   logic [MOD_W-1:0] imod_next;
   logic [MOD_W-1:0] mm_val;

   // Shared modular multiplier
   bmp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req_ff),
      .mm_rsp (mm_rsp)
   );

   assign mm_val = mm_rsp.value;

   // i mod p tracked by a wrapping counter
   assign imod_inc  = imod_ff + MOD_W'(1);
   assign imod_next = (imod_inc == mod_ff) ? '0 : imod_inc;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      imod_in       = imod_ff;
      factr_in      = factr_ff;
      factk_in      = factk_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      exp_in        = exp_ff;
      res_in        = res_ff;
      second_in     = second_ff;
      mod_in        = csr_write_enable ? csr_write_data : mod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      mm_req_in         = mm_req_ff;
      mm_req_in.start   = 1'b0;
      mm_req_in.modulus = mod_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = req_n_value;
               r_in     = req_r_value;
               k_in     = req_n_value - req_r_value;
               i_in     = N_BITS'(1);
               imod_in  = MOD_W'(1);
               factr_in = MOD_W'(1);
               factk_in = MOD_W'(1);
               if (mod_ff < MOD_W'(2)) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else if (req_r_value == '0) begin
                  res_in   = MOD_W'(1);
                  state_in = ST_DONE;
               end else if (req_r_value > req_n_value) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  // first factorial term: 1 * (1 mod p)
                  mm_req_in.start = 1'b1;
                  mm_req_in.op_a  = MOD_W'(1);
                  mm_req_in.op_b  = MOD_W'(1);
                  state_in        = ST_FACT;
               end
            end
         end

         // running product, capturing r! and (n-r)! on the way
         ST_FACT: begin
            if (mm_rsp.done) begin
               if (i_ff == r_ff) begin
                  factr_in = mm_val;
               end
               if (i_ff == k_ff) begin
                  factk_in = mm_val;
               end
               if (i_ff == n_ff) begin
                  res_in    = mm_val;
                  acc_in    = MOD_W'(1);
                  sq_in     = (i_ff == r_ff) ? mm_val : factr_ff;
                  exp_in    = mod_ff - MOD_W'(2);
                  second_in = 1'b0;
                  state_in  = ST_POW_CHK;
               end else begin
                  i_in            = i_ff + N_BITS'(1);
                  imod_in         = imod_next;
                  mm_req_in.start = 1'b1;
                  mm_req_in.op_a  = mm_val;
                  mm_req_in.op_b  = imod_next;
               end
            end
         end

         // square-and-multiply, exponent bits from the bottom
         ST_POW_CHK: begin
            mm_req_in.start = 1'b1;
            if (exp_ff == '0) begin
               mm_req_in.op_a = res_ff;
               mm_req_in.op_b = acc_ff;
               state_in       = ST_FIN;
            end else if (exp_ff[0]) begin
               mm_req_in.op_a = acc_ff;
               mm_req_in.op_b = sq_ff;
               state_in       = ST_POW_ACC;
            end else begin
               mm_req_in.op_a = sq_ff;
               mm_req_in.op_b = sq_ff;
               state_in       = ST_POW_SQ;
            end
         end

         ST_POW_ACC: begin
            if (mm_rsp.done) begin
               acc_in          = mm_val;
               mm_req_in.start = 1'b1;
               mm_req_in.op_a  = sq_ff;
               mm_req_in.op_b  = sq_ff;
               state_in        = ST_POW_SQ;
            end
         end

         ST_POW_SQ: begin
            if (mm_rsp.done) begin
               sq_in    = mm_val;
               exp_in   = {1'b0, exp_ff[MOD_W-1:1]};
               state_in = ST_POW_CHK;
            end
         end

         // fold in one inverse; the second pass inverts (n-r)!
         ST_FIN: begin
            if (mm_rsp.done) begin
               res_in = mm_val;
               if (!second_ff) begin
                  second_in = 1'b1;
                  acc_in    = MOD_W'(1);
                  sq_in     = factk_ff;
                  exp_in    = mod_ff - MOD_W'(2);
                  state_in  = ST_POW_CHK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         mod_ff          <= MOD_RESET;
         mm_req_ff.start <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         mod_ff          <= mod_in;
         mm_req_ff.start <= mm_req_in.start;
      end
      mm_req_ff.op_a    <= mm_req_in.op_a;
      mm_req_ff.op_b    <= mm_req_in.op_b;
      mm_req_ff.modulus <= mm_req_in.modulus;
      n_ff          <= n_in;
      r_ff          <= r_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      imod_ff       <= imod_in;
      factr_ff      <= factr_in;
      factk_ff      <= factk_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      exp_ff        <= exp_in;
      res_ff        <= res_in;
      second_ff     <= second_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // An accepted item always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE)
      else $error("item accepted but sequencer stayed idle");

   // Multiplier replies only arrive in a waiting state
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == ST_FACT || state_ff == ST_POW_ACC ||
                       state_ff == ST_POW_SQ || state_ff == ST_FIN))
      else $error("multiplier reply outside a waiting state");

   // A start is always paired with a state that waits for it
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      mm_req_ff.start |-> (state_ff == ST_FACT || state_ff == ST_POW_ACC ||
                           state_ff == ST_POW_SQ || state_ff == ST_FIN))
      else $error("multiplier started with no state waiting");

   // A finished item holds while the result register is still occupied
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> state_ff == ST_DONE)
      else $error("result dropped while output was stalled");

endmodule

>>> sv/bmp_mulmod.sv
`timescale 1ns / 1ps

// Modular multiplier: one 30x30 product, then the 60-bit product is reduced
// two bits per cycle against p, 2p and 3p. Operands must be below p.
module bmp_mulmod
   import bmp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  bmp_mm_req_type mm_req,
   output bmp_mm_rsp_type mm_rsp
);

   localparam int RED_STEPS = MOD_W / 2;
   localparam int CNT_W     = $clog2(RED_STEPS + 1);

   logic [MOD_W-1:0] rem_ff, rem_in;
   logic [MOD_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MOD_W-1:0] p_ff, p_in;
   logic [MOD_W+1:0] p3_ff, p3_in;
   logic             done_ff, done_in;

   logic [2*MOD_W-1:0] prod;
   logic [MOD_W+2:0]   x_ext;
   logic [MOD_W+2:0]   d1;
   logic [MOD_W+2:0]   d2;
   logic [MOD_W+2:0]   d3;
   logic [MOD_W-1:0]   rem_red;

   // Top half of a product of two residues is already below p
   assign prod = mm_req.op_a * mm_req.op_b;

   // One radix-4 step: shift in two bits, subtract the largest multiple that fits
   always_comb begin
      x_ext = {1'b0, rem_ff, lo_ff[MOD_W-1 -: 2]};
      d1    = x_ext - {3'b000, p_ff};
      d2    = x_ext - {2'b00, p_ff, 1'b0};
      d3    = x_ext - {1'b0, p3_ff};
      if (!d3[MOD_W+2]) begin
         rem_red = d3[MOD_W-1:0];
      end else if (!d2[MOD_W+2]) begin
         rem_red = d2[MOD_W-1:0];
      end else if (!d1[MOD_W+2]) begin
         rem_red = d1[MOD_W-1:0];
      end else begin
         rem_red = x_ext[MOD_W-1:0];
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      p_in    = p_ff;
      p3_in   = p3_ff;
      done_in = 1'b0;
      if (mm_req.start) begin
         rem_in = prod[2*MOD_W-1:MOD_W];
         lo_in  = prod[MOD_W-1:0];
         cnt_in = CNT_W'(RED_STEPS);
         p_in   = mm_req.modulus;
         p3_in  = {2'b00, mm_req.modulus} + {1'b0, mm_req.modulus, 1'b0};
      end else if (cnt_ff != '0) begin
         rem_in  = rem_red;
         lo_in   = {lo_ff[MOD_W-3:0], 2'b00};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      p_ff   <= p_in;
      p3_ff  <= p3_in;
   end

   assign mm_rsp.done  = done_ff;
   assign mm_rsp.value = rem_ff;

   // A new product is never started over one still being reduced
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> cnt_ff == '0)
      else $error("multiplier started while busy");

endmodule
